FILE: hw/rtl/ssb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, widths and codes of the single-source betweenness block.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int unsigned MaxNodesDef = 1024;
  localparam int unsigned MaxEdgesDef = 8192;

  localparam int unsigned OpW    = 2;
  localparam int unsigned IndexW = 13;
  localparam int unsigned ValueW = 14;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned NodeW  = 10;
  localparam int unsigned DistW  = 11;
  localparam int unsigned SigmaW = 48;
  localparam int unsigned DepW   = 40;
  localparam int unsigned FactW  = 41;

  localparam logic [OpW-1:0] OP_ROW  = 2'd0;
  localparam logic [OpW-1:0] OP_EDGE = 2'd1;
  localparam logic [OpW-1:0] OP_RUN  = 2'd2;
  localparam logic [OpW-1:0] OP_READ = 2'd3;

  localparam logic [FactW-1:0] FIX_ONE = 41'h100_0000 >> 8;

  typedef struct packed {
    logic signed [DistW-1:0] hops;
    logic [SigmaW-1:0]       sigma;
    logic [DepW-1:0]         delta;
  } node_t;

  typedef struct packed {
    logic              start;
    logic [SigmaW-1:0] a;
    logic [FactW-1:0]  b;
    logic [SigmaW-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic            done;
    logic [DepW-1:0] q;
  } md_rsp_t;

endpackage

FILE: hw/rtl/ssb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_req_if
// Request channel: valid/ready with op, index and value.
// ----------------------------------------------------------------------------
interface ssb_req_if;
  logic                        valid;
  logic                        ready;
  logic [ssb_pkg::OpW-1:0]     op;
  logic [ssb_pkg::IndexW-1:0]  index;
  logic [ssb_pkg::ValueW-1:0]  value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

FILE: hw/rtl/ssb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_rsp_if
// Result channel: valid/ready with one node's results or a run completion.
// ----------------------------------------------------------------------------
interface ssb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ssb_pkg::NodeW-1:0]         node;
  logic signed [ssb_pkg::DistW-1:0]  distance;
  logic [ssb_pkg::SigmaW-1:0]        path_count;
  logic [ssb_pkg::DepW-1:0]          centrality;
  logic                              done_flag;

  modport source (output valid, output node, output distance, output path_count,
                  output centrality, output done_flag, input ready);
  modport sink   (input valid, input node, input distance, input path_count,
                  input centrality, input done_flag, output ready);
endinterface

FILE: hw/rtl/single_source_betweenness.sv
`timescale 1ns / 1ps
// Row and edge loads are taken back to back; a read goes through the node memory read and
// the output register to its result. A run first clears the node memory, then visits each
// reached node and its edges forward, and per level scans every node and its edges, using
// the multiply-divide unit for each term.
// Reset: control clears at once, then the node memory is swept (distance -1, counts 0)
// while no request is taken; configuration writes are taken always.
// ----------------------------------------------------------------------------
// single_source_betweenness
// Brandes single-source dependency over a compressed-row graph held in memory.
// ----------------------------------------------------------------------------
module single_source_betweenness #(
  parameter int unsigned MAX_NODES = ssb_pkg::MaxNodesDef,
  parameter int unsigned MAX_EDGES = ssb_pkg::MaxEdgesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssb_pkg::CfgW-1:0]     cfg_wdata_i,
  ssb_req_if.sink                      req_i,
  ssb_rsp_if.source                    rsp_o
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned RAW = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned VW  = ssb_pkg::ValueW;
  localparam int unsigned DW  = ssb_pkg::DistW;
  localparam int unsigned SW  = ssb_pkg::SigmaW;
  localparam int unsigned PW  = ssb_pkg::DepW;

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_INIT  = 5'd3;
  localparam logic [4:0] S_POP   = 5'd4;
  localparam logic [4:0] S_U     = 5'd5;
  localparam logic [4:0] S_U2    = 5'd6;
  localparam logic [4:0] S_U3    = 5'd7;
  localparam logic [4:0] S_FEDGE = 5'd8;
  localparam logic [4:0] S_FW    = 5'd9;
  localparam logic [4:0] S_FWR   = 5'd10;
  localparam logic [4:0] S_KINIT = 5'd11;
  localparam logic [4:0] S_KV    = 5'd12;
  localparam logic [4:0] S_KV2   = 5'd13;
  localparam logic [4:0] S_KV3   = 5'd14;
  localparam logic [4:0] S_KEDGE = 5'd15;
  localparam logic [4:0] S_KW    = 5'd16;
  localparam logic [4:0] S_KWR   = 5'd17;
  localparam logic [4:0] S_KMD   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  // Memories: node state, row starts, edge targets, frontier queue
  ssb_pkg::node_t node_mem [MAX_NODES];
  logic [VW-1:0]  row_mem  [MAX_NODES + 1];
  logic [VW-1:0]  edge_mem [MAX_EDGES];
  logic [NW-1:0]  queue_mem [MAX_NODES];

  logic           nm_re, nm_we;
  logic [NW-1:0]  nm_ra, nm_wa;
  ssb_pkg::node_t nm_wd, nm_rd_q;
  logic           rm_re, rm_we;
  logic [RAW-1:0] rm_ra, rm_wa;
  logic [VW-1:0]  rm_rd_q;
  logic           em_re, em_we;
  logic [EAW-1:0] em_ra, em_wa;
  logic [VW-1:0]  em_rd_q;
  logic           qm_re, qm_we;
  logic [NW-1:0]  qm_ra, qm_wa, qm_wd, qm_rd_q;

  logic [4:0]     state_q, state_d;
  logic [NW-1:0]  clr_q, clr_d;
  logic           run_q, run_d;
  logic [VW-1:0]  src_q, src_d;
  logic [NCW-1:0] n_q;
  logic [NW:0]    head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]  u_q, u_d;
  logic signed [DW-1:0] du_q, du_d, lvl_q, lvl_d, done_dist_q, done_dist_d;
  logic [SW-1:0]  su_q, su_d;
  logic [VW-1:0]  k_q, k_d, e_q, e_d;
  logic [DW-1:0]  deep_q, deep_d;
  logic [NCW-1:0] v_q, v_d;
  ssb_pkg::node_t cur_q, cur_d;
  logic [PW-1:0]  acc_q, acc_d;
  logic           hit_q, hit_d;

  logic           out_v_q, out_v_d;
  logic [ssb_pkg::NodeW-1:0] out_node_q, out_node_d;
  logic signed [DW-1:0]      out_dist_q, out_dist_d;
  logic [SW-1:0]  out_pc_q, out_pc_d;
  logic [PW-1:0]  out_cen_q, out_cen_d;
  logic           out_done_q, out_done_d;

  ssb_pkg::md_req_t md_req;
  ssb_pkg::md_rsp_t md_rsp;

  logic           accept, out_free;
  logic signed [DW-1:0] nd;
  logic [SW:0]    ssum;
  logic [PW:0]    dsum;
  logic [VW-1:0]  row_clip;
  logic [31:0]    cfg_clamp;

  assign accept   = req_i.valid & req_i.ready;
  assign out_free = ~out_v_q | rsp_o.ready;
  assign nd       = du_q + DW'(1);
  assign ssum     = {1'b0, nm_rd_q.sigma} + {1'b0, su_q};
  assign dsum     = {1'b0, acc_q} + {1'b0, md_rsp.q};
  assign row_clip = (32'(rm_rd_q) > MAX_EDGES) ? VW'(MAX_EDGES) : rm_rd_q;

  always_comb begin
    // defaults: hold everything, no memory access
    state_d = state_q; clr_d = clr_q; run_d = run_q; src_d = src_q;
    head_d = head_q; tail_d = tail_q; u_d = u_q; du_d = du_q; su_d = su_q;
    k_d = k_q; e_d = e_q; deep_d = deep_q; lvl_d = lvl_q; v_d = v_q;
    cur_d = cur_q; acc_d = acc_q; hit_d = hit_q; done_dist_d = done_dist_q;
    out_v_d = out_v_q & ~rsp_o.ready;
    out_node_d = out_node_q; out_dist_d = out_dist_q; out_pc_d = out_pc_q;
    out_cen_d = out_cen_q; out_done_d = out_done_q;
    nm_re = 1'b0; nm_ra = '0; nm_we = 1'b0; nm_wa = '0; nm_wd = '0;
    rm_re = 1'b0; rm_ra = '0; rm_we = 1'b0; rm_wa = RAW'(req_i.index);
    em_re = 1'b0; em_ra = EAW'(k_q); em_we = 1'b0; em_wa = EAW'(req_i.index);
    qm_re = 1'b0; qm_ra = head_q[NW-1:0]; qm_we = 1'b0; qm_wa = '0; qm_wd = '0;
    md_req.start = 1'b0; md_req.a = cur_q.sigma;
    md_req.b = ssb_pkg::FIX_ONE + {1'b0, nm_rd_q.delta}; md_req.c = nm_rd_q.sigma;
    req_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          case (req_i.op)
            ssb_pkg::OP_ROW:  rm_we = (32'(req_i.index) <= MAX_NODES);
            ssb_pkg::OP_EDGE: em_we = (32'(req_i.index) < MAX_EDGES);
            ssb_pkg::OP_RUN: begin
              // clear the per-run state, then traverse
              src_d = req_i.value; run_d = 1'b1; clr_d = '0; state_d = S_CLR;
            end
            default: begin
              src_d = VW'(req_i.index);
              hit_d = (32'(req_i.index) < 32'(n_q));
              nm_re = 1'b1; nm_ra = NW'(req_i.index);
              state_d = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_v_d = 1'b1; out_node_d = src_q[ssb_pkg::NodeW-1:0]; out_done_d = 1'b0;
          if (hit_q) begin
            out_dist_d = nm_rd_q.hops; out_pc_d = nm_rd_q.sigma;
            out_cen_d = nm_rd_q.delta >> 1;   // final halving applied on read
          end else begin
            out_dist_d = -DW'(1); out_pc_d = '0; out_cen_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        nm_we = 1'b1; nm_wa = clr_q;
        nm_wd.hops = -DW'(1); nm_wd.sigma = '0; nm_wd.delta = '0;
        clr_d = clr_q + NW'(1);
        deep_d = '0;
        if (clr_q == NW'(MAX_NODES - 1)) begin
          run_d = 1'b0;
          if (!run_q) begin
            state_d = S_IDLE;
          end else if (32'(src_q) < 32'(n_q)) begin
            state_d = S_INIT;
          end else begin
            done_dist_d = -DW'(1); state_d = S_DONE;
          end
        end
      end
      S_INIT: begin
        nm_we = 1'b1; nm_wa = NW'(src_q);
        nm_wd.hops = '0; nm_wd.sigma = SW'(1); nm_wd.delta = '0;
        qm_we = 1'b1; qm_wa = '0; qm_wd = NW'(src_q);
        head_d = '0; tail_d = (NW+1)'(1);
        state_d = S_POP;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_KINIT;
        end else begin
          qm_re = 1'b1; head_d = head_q + (NW+1)'(1); state_d = S_U;
        end
      end
      S_U: begin
        u_d = qm_rd_q;
        nm_re = 1'b1; nm_ra = qm_rd_q;
        rm_re = 1'b1; rm_ra = RAW'(qm_rd_q);
        state_d = S_U2;
      end
      S_U2: begin
        du_d = nm_rd_q.hops; su_d = nm_rd_q.sigma; k_d = rm_rd_q;
        rm_re = 1'b1; rm_ra = RAW'(u_q) + RAW'(1);
        state_d = S_U3;
      end
      S_U3: begin
        e_d = row_clip; state_d = S_FEDGE;
      end
      S_FEDGE: begin
        if (k_q >= e_q) begin
          state_d = S_POP;
        end else begin
          em_re = 1'b1; k_d = k_q + VW'(1); state_d = S_FW;
        end
      end
      S_FW: begin
        if (32'(em_rd_q) >= 32'(n_q)) begin
          state_d = S_FEDGE;   // drop out-of-range destination
        end else begin
          nm_re = 1'b1; nm_ra = NW'(em_rd_q); u_d = u_q; state_d = S_FWR;
          cur_d.hops = '0; cur_d.sigma = '0; cur_d.delta = PW'(em_rd_q);
        end
      end
      S_FWR: begin
        nm_wa = NW'(cur_q.delta);
        nm_wd.hops = nd; nm_wd.delta = nm_rd_q.delta;
        nm_wd.sigma = ssum[SW] ? '1 : ssum[SW-1:0];
        if (nm_rd_q.hops == -DW'(1)) begin
          nm_we = 1'b1;
          if (deep_q < DW'(nd)) deep_d = DW'(nd);
          if (32'(tail_q) < MAX_NODES) begin
            qm_we = 1'b1; qm_wa = tail_q[NW-1:0]; qm_wd = NW'(cur_q.delta);
            tail_d = tail_q + (NW+1)'(1);
          end
        end else if (nm_rd_q.hops == nd) begin
          nm_we = 1'b1;
        end
        state_d = S_FEDGE;
      end
      S_KINIT: begin
        lvl_d = $signed(deep_q) - DW'(1); v_d = '0;
        if (deep_q <= DW'(1)) begin
          done_dist_d = $signed(deep_q); state_d = S_DONE;
        end else begin
          state_d = S_KV;
        end
      end
      S_KV: begin
        if (v_q >= n_q) begin
          if (lvl_q == DW'(1)) begin
            done_dist_d = $signed(deep_q); state_d = S_DONE;
          end else begin
            lvl_d = lvl_q - DW'(1); v_d = '0;
          end
        end else begin
          nm_re = 1'b1; nm_ra = NW'(v_q);
          rm_re = 1'b1; rm_ra = RAW'(v_q);
          state_d = S_KV2;
        end
      end
      S_KV2: begin
        cur_d = nm_rd_q; acc_d = nm_rd_q.delta;
        if (nm_rd_q.hops != lvl_q) begin
          v_d = v_q + NCW'(1); state_d = S_KV;
        end else begin
          k_d = rm_rd_q; rm_re = 1'b1; rm_ra = RAW'(v_q) + RAW'(1); state_d = S_KV3;
        end
      end
      S_KV3: begin
        e_d = row_clip; state_d = S_KEDGE;
      end
      S_KEDGE: begin
        if (k_q >= e_q) begin
          // write back the accumulated dependency of v
          nm_we = 1'b1; nm_wa = NW'(v_q);
          nm_wd.hops = cur_q.hops; nm_wd.sigma = cur_q.sigma; nm_wd.delta = acc_q;
          v_d = v_q + NCW'(1); state_d = S_KV;
        end else begin
          em_re = 1'b1; k_d = k_q + VW'(1); state_d = S_KW;
        end
      end
      S_KW: begin
        if (32'(em_rd_q) >= 32'(n_q)) begin
          state_d = S_KEDGE;
        end else begin
          nm_re = 1'b1; nm_ra = NW'(em_rd_q); state_d = S_KWR;
        end
      end
      S_KWR: begin
        if (nm_rd_q.hops != lvl_q + DW'(1) || nm_rd_q.sigma == '0) begin
          state_d = S_KEDGE;
        end else begin
          md_req.start = 1'b1; state_d = S_KMD;
        end
      end
      S_KMD: begin
        if (md_rsp.done) begin
          acc_d = dsum[PW] ? '1 : dsum[PW-1:0];
          state_d = S_KEDGE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_v_d = 1'b1; out_node_d = src_q[ssb_pkg::NodeW-1:0];
          out_dist_d = done_dist_q; out_pc_d = '0; out_cen_d = '0; out_done_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // node-count register: zero reads as one, overlarge clamps to the depth
  always_comb begin
    cfg_clamp = 32'(cfg_wdata_i);
    if (cfg_clamp == 32'd0) cfg_clamp = 32'd1;
    if (cfg_clamp > MAX_NODES) cfg_clamp = MAX_NODES;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; run_q <= 1'b0; n_q <= NCW'(1);
      head_q <= '0; tail_q <= '0; deep_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; run_q <= run_d;
      head_q <= head_d; tail_q <= tail_d; deep_q <= deep_d; out_v_q <= out_v_d;
      if (cfg_we_i) n_q <= NCW'(cfg_clamp);
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; u_q <= u_d; du_q <= du_d; su_q <= su_d; k_q <= k_d; e_q <= e_d;
    lvl_q <= lvl_d; v_q <= v_d; cur_q <= cur_d; acc_q <= acc_d; hit_q <= hit_d;
    done_dist_q <= done_dist_d;
    out_node_q <= out_node_d; out_dist_q <= out_dist_d; out_pc_q <= out_pc_d;
    out_cen_q <= out_cen_d; out_done_q <= out_done_d;
  end

  // memories, registered reads
  always_ff @(posedge clk_i) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    if (nm_re) nm_rd_q <= node_mem[nm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rm_we) row_mem[rm_wa] <= req_i.value;
    if (rm_re) rm_rd_q <= row_mem[rm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (em_we) edge_mem[em_wa] <= req_i.value;
    if (em_re) em_rd_q <= edge_mem[em_ra];
  end

  always_ff @(posedge clk_i) begin
    if (qm_we) queue_mem[qm_wa] <= qm_wd;
    if (qm_re) qm_rd_q <= queue_mem[qm_ra];
  end

  ssb_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.node       = out_node_q;
  assign rsp_o.distance   = out_dist_q;
  assign rsp_o.path_count = out_pc_q;
  assign rsp_o.centrality = out_cen_q;
  assign rsp_o.done_flag  = out_done_q;

  // the queue never pops past what was pushed
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("frontier head passed tail");

  // a run request always starts with the clearing sweep
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op == ssb_pkg::OP_RUN) |=> (state_q == S_CLR && clr_q == '0))
    else $error("run did not start clearing");

  // the divider only answers while the sequencer waits for it
  a_md_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> state_q == S_KMD) else $error("stray divider result");

  // the deepest level stays below MAX_NODES
  a_deep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(deep_q) < MAX_NODES) else $error("deepest level out of range");

endmodule

FILE: hw/rtl/ssb_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_muldiv
// floor(a * b / c) saturated to 40 bits: four 32x32 partial products, then
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssb_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssb_pkg::md_req_t req_i,
  output ssb_pkg::md_rsp_t rsp_o
);

  localparam int unsigned PW = ssb_pkg::SigmaW + ssb_pkg::FactW;
  localparam int unsigned DW = ssb_pkg::DepW;
  localparam int unsigned SW = ssb_pkg::SigmaW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [SW-1:0] a_q, a_d, c_q, c_d;
  logic [ssb_pkg::FactW-1:0] b_q, b_d;
  logic [63:0]   pp_q, pp_d;
  logic [1:0]    sh_q, sh_d;
  logic          ppv_q, ppv_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [DW-1:0] lo_q, lo_d, quo_q, quo_d;
  logic          done_q, done_d;
  logic [31:0]   opx, opy;
  logic [PW-1:0] pp_sh;
  logic [SW:0]   trial;

  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin opx = a_q[31:0]; opy = b_q[31:0]; end
      2'd1: begin opx = a_q[31:0]; opy = 32'(b_q[ssb_pkg::FactW-1:32]); end
      2'd2: begin opx = 32'(a_q[SW-1:32]); opy = b_q[31:0]; end
      default: begin opx = 32'(a_q[SW-1:32]); opy = 32'(b_q[ssb_pkg::FactW-1:32]); end
    endcase
    case (sh_q)
      2'd0:    pp_sh = PW'(pp_q);
      2'd1:    pp_sh = PW'(pp_q) << 32;
      default: pp_sh = PW'(pp_q) << 64;
    endcase
    trial = {rem_q, lo_q[DW-1]};
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; a_d = a_q; b_d = b_q; c_d = c_q;
    pp_d = pp_q; sh_d = sh_q; ppv_d = 1'b0; acc_d = acc_q;
    rem_d = rem_q; lo_d = lo_q; quo_d = quo_q; done_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          a_d = req_i.a; b_d = req_i.b; c_d = req_i.c;
          acc_d = '0; cnt_d = '0; state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (ppv_q) acc_d = acc_q + pp_sh;
        if (cnt_q < 6'd4) begin
          pp_d = opx * opy;
          sh_d = (cnt_q == 6'd0) ? 2'd0 : (cnt_q == 6'd3) ? 2'd2 : 2'd1;
          ppv_d = 1'b1;
          cnt_d = cnt_q + 6'd1;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (acc_q[PW-1:DW] >= {1'b0, c_q}) begin
          quo_d = '1; done_d = 1'b1; state_d = ST_IDLE;
        end else begin
          rem_d = acc_q[PW-2:DW]; lo_d = acc_q[DW-1:0]; cnt_d = '0; state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, c_q}) begin
          rem_d = SW'(trial - {1'b0, c_q}); quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_d = trial[SW-1:0]; quo_d = {quo_q[DW-2:0], 1'b0};
        end
        lo_d = lo_q << 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DW - 1)) begin
          done_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; ppv_q <= 1'b0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ppv_q <= ppv_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; pp_q <= pp_d; sh_q <= sh_d;
    acc_q <= acc_d; rem_q <= rem_d; lo_q <= lo_d; quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule
